@@ design/ggc_pkg.sv @@
// ----------------------------------------------------------------------------
// ggc_pkg
// Shared types and constants for the greedy graph coloring unit.
// ----------------------------------------------------------------------------
package ggc_pkg;

  localparam int MAX_VERTICES_DEF = 32;
  localparam int FIELD_W          = 6;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_RUN  = 1'b1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EDGE,
    ST_ROW,
    ST_SCAN,
    ST_PICK
  } state_t;

endpackage

@@ design/greedy_graph_coloring_unit.sv @@
// ----------------------------------------------------------------------------
// greedy_graph_coloring_unit
// Greedy first-fit vertex coloring over a stored lower-triangle adjacency
// matrix, one row per vertex, with one shared color-RAM read per cycle.
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_stall  | mode, first_end, second_end
//  out     | output    | out_valid / out_stall| vertex, color, last_of_run
//  cfg     | input     | cfg_write            | cfg_data -> vertex_count
//
//  Edge item: read-modify-write of one adjacency row; a dropped edge is not written.
//  Run item: each vertex passes ST_ROW, ST_SCAN (one earlier neighbor color
//  read per cycle) and ST_PICK, then a sweep clears the adjacency rows.
//  After reset the same sweep runs; in_stall is high meanwhile.
//  A stalled result holds the sequencer only when the next result is ready.
// ----------------------------------------------------------------------------
module greedy_graph_coloring_unit
  import ggc_pkg::*;
#(
  parameter int MAX_VERTICES = MAX_VERTICES_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_write,
  input  logic [FIELD_W-1:0] cfg_data,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               mode,
  input  logic [FIELD_W-1:0] first_end,
  input  logic [FIELD_W-1:0] second_end,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [FIELD_W-1:0] vertex,
  output logic [FIELD_W-1:0] color,
  output logic               last_of_run
);

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int CW = $clog2(MAX_VERTICES + 1);
  localparam int UW = MAX_VERTICES + 1;
  localparam logic [FIELD_W-1:0] MAX_F  = FIELD_W'(MAX_VERTICES);
  localparam logic [VW-1:0]      LAST_V = VW'(MAX_VERTICES - 1);

  state_t state, state_next;

  logic [FIELD_W-1:0] vertex_count;
  logic [FIELD_W-1:0] n_eff;

  logic [VW-1:0] idx, idx_next;
  logic [VW-1:0] nb, nb_next;
  logic [VW-1:0] clr_cnt, clr_cnt_next;
  logic [VW-1:0] hi, hi_next;
  logic [VW-1:0] lo, lo_next;
  logic [UW-1:0] used, used_next;
  logic [CW-1:0] pick;

  logic [FIELD_W-1:0] edge_max, edge_min;
  logic               edge_ok;
  logic               is_last;
  logic               out_load;

  logic                    adj_we;
  logic [VW-1:0]           adj_waddr, adj_raddr;
  logic [MAX_VERTICES-1:0] adj_wdata, adj_rdata;
  logic                    col_we;
  logic [VW-1:0]           col_raddr;
  logic [CW-1:0]           col_rdata;

  ggc_ram #(.WIDTH(MAX_VERTICES), .DEPTH(MAX_VERTICES)) u_adj (
    .clk  (clk),
    .we   (adj_we),
    .waddr(adj_waddr),
    .wdata(adj_wdata),
    .raddr(adj_raddr),
    .rdata(adj_rdata)
  );

  ggc_ram #(.WIDTH(CW), .DEPTH(MAX_VERTICES)) u_col (
    .clk  (clk),
    .we   (col_we),
    .waddr(idx),
    .wdata(pick),
    .raddr(col_raddr),
    .rdata(col_rdata)
  );

  always_comb begin
    if (vertex_count == '0) begin
      n_eff = FIELD_W'(1);
    end else if (vertex_count > MAX_F) begin
      n_eff = MAX_F;
    end else begin
      n_eff = vertex_count;
    end
  end

  assign edge_max = (first_end > second_end) ? first_end : second_end;
  assign edge_min = (first_end > second_end) ? second_end : first_end;
  assign edge_ok  = (edge_min != '0) && (edge_max <= n_eff) && (first_end != second_end);
  assign is_last  = (FIELD_W'(idx) + FIELD_W'(1)) == n_eff;

  // first free color from 1 upward
  always_comb begin
    pick = '0;
    for (int c = MAX_VERTICES; c >= 1; c--) begin
      if (!used[c]) begin
        pick = CW'(c);
      end
    end
  end

  always_comb begin
    state_next   = state;
    idx_next     = idx;
    nb_next      = nb;
    clr_cnt_next = clr_cnt;
    hi_next      = hi;
    lo_next      = lo;
    used_next    = used;
    in_stall     = 1'b1;
    adj_we       = 1'b0;
    adj_waddr    = idx;
    adj_wdata    = '0;
    adj_raddr    = idx;
    col_we       = 1'b0;
    col_raddr    = nb + VW'(1);
    out_load     = 1'b0;
    case (state)
      ST_CLEAR: begin
        adj_we    = 1'b1;
        adj_waddr = clr_cnt;
        if (clr_cnt == LAST_V) begin
          state_next = ST_IDLE;
        end else begin
          clr_cnt_next = clr_cnt + VW'(1);
        end
      end
      ST_IDLE: begin
        in_stall  = 1'b0;
        adj_raddr = VW'(edge_max - FIELD_W'(1));
        if (in_valid) begin
          if (mode == MODE_RUN) begin
            idx_next   = '0;
            state_next = ST_ROW;
          end else if (edge_ok) begin
            hi_next    = VW'(edge_max - FIELD_W'(1));
            lo_next    = VW'(edge_min - FIELD_W'(1));
            state_next = ST_EDGE;
          end
        end
      end
      ST_EDGE: begin
        adj_we     = 1'b1;
        adj_waddr  = hi;
        adj_wdata  = adj_rdata | (MAX_VERTICES'(1) << lo);
        state_next = ST_IDLE;
      end
      ST_ROW: begin
        col_raddr  = '0;
        nb_next    = '0;
        used_next  = '0;
        state_next = ST_SCAN;
      end
      ST_SCAN: begin
        if ((nb < idx) && adj_rdata[nb]) begin
          used_next = used | (UW'(1) << col_rdata);
        end
        if (({1'b0, nb} + (VW+1)'(1)) >= {1'b0, idx}) begin
          state_next = ST_PICK;
        end else begin
          nb_next = nb + VW'(1);
        end
      end
      ST_PICK: begin
        if (!out_valid || !out_stall) begin
          out_load = 1'b1;
          col_we   = 1'b1;
          if (is_last) begin
            clr_cnt_next = '0;
            state_next   = ST_CLEAR;
          end else begin
            idx_next   = idx + VW'(1);
            state_next = ST_ROW;
          end
        end
      end
      default: begin
        state_next = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      idx          <= '0;
      nb           <= '0;
      out_valid    <= 1'b0;
      vertex_count <= FIELD_W'(1);
    end else begin
      clr_cnt <= clr_cnt_next;
      idx     <= idx_next;
      nb      <= nb_next;
      if (cfg_write) begin
        vertex_count <= cfg_data;
      end
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    hi   <= hi_next;
    lo   <= lo_next;
    used <= used_next;
    if (out_load) begin
      vertex      <= FIELD_W'(idx) + FIELD_W'(1);
      color       <= FIELD_W'(pick);
      last_of_run <= is_last;
    end
  end

  a_color_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (color != '0) && (color <= vertex))
    else $error("color outside 1..vertex");

  a_last_is_n: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_of_run |-> vertex == n_eff)
    else $error("last flag on wrong vertex");

  a_no_adj_write_idle: assert property (@(posedge clk) disable iff (rst)
    (state == ST_IDLE) |-> !adj_we)
    else $error("adjacency write while idle");

  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall && (mode == MODE_RUN) |=> in_stall)
    else $error("item taken during run");

endmodule

@@ design/ggc_ram.sv @@
// ----------------------------------------------------------------------------
// ggc_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module ggc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
